// File: hw/rtl/wls_pkg.sv
`default_nettype none

package wls_pkg;

  localparam int MAX_ENTRIES = 6;

  localparam int ROLL_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 3;
  localparam int WEIGHT_W = 10;
  localparam int INDEX_W = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  // Sum of all weights at full scale fits here.
  localparam int SUM_W  = WEIGHT_W + $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W = ROLL_W + SUM_W;

  localparam logic [ROLL_W-1:0] ROLL_ONE = ROLL_W'(1) << FRAC_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BASE = 3'd2;

  typedef enum logic [STATUS_W-1:0] {
    PICK_HIT  = 2'd0,
    PICK_ZERO = 2'd1,
    PICK_NONE = 2'd2,
    PICK_LAST = 2'd3
  } pick_status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                      entry_count;
    logic [MAX_ENTRIES-1:0]                  enable_mask;
    logic [MAX_ENTRIES-1:0][WEIGHT_W-1:0]    weight;
  } wls_cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] chosen_index;
    pick_status_t       pick_status;
  } pick_t;

endpackage

`default_nettype wire

// File: hw/rtl/wls_req_if.sv
`default_nettype none

interface wls_req_if import wls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROLL_W-1:0] roll;

  modport source (output valid, output roll, input ready);
  modport sink   (input valid, input roll, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wls_rsp_if.sv
`default_nettype none

interface wls_rsp_if import wls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  chosen_index;
  logic [STATUS_W-1:0] pick_status;

  modport source (output valid, output chosen_index, output pick_status, input ready);
  modport sink   (input valid, input chosen_index, input pick_status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wls_pick.sv
`default_nettype none

module wls_pick import wls_pkg::*; (
  input  wls_cfg_t          cfg,
  input  logic [ROLL_W-1:0] roll,
  output pick_t             pick
);

  logic [COUNT_W-1:0]                 eff_count;
  logic [MAX_ENTRIES-1:0]             part;
  logic [MAX_ENTRIES-1:0][SUM_W-1:0]  run;
  logic [MAX_ENTRIES-1:0]             hit;
  logic [SUM_W-1:0]                   total;
  logic [PROD_W-1:0]                  target;

  always_comb begin
    logic [SUM_W-1:0] acc;
    eff_count = (cfg.entry_count > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
                                                          : cfg.entry_count;
    acc = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      part[i] = (COUNT_W'(i) < eff_count) && cfg.enable_mask[i];
      if (part[i]) begin
        acc = acc + SUM_W'(cfg.weight[i]);
      end
      run[i] = acc;
    end
    total  = acc;
    target = PROD_W'(roll) * PROD_W'(total);
    // Running sum scaled to the roll's fraction reaches the cursor.
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = part[i] && (PROD_W'({run[i], {FRAC_W{1'b0}}}) >= target);
    end
  end

  always_comb begin
    logic [INDEX_W-1:0] first_idx;
    logic [INDEX_W-1:0] last_idx;
    logic [INDEX_W-1:0] hit_idx;
    first_idx = '0;
    last_idx  = '0;
    hit_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (part[i]) first_idx = INDEX_W'(i);
      if (hit[i])  hit_idx   = INDEX_W'(i);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (part[i]) last_idx = INDEX_W'(i);
    end

    if (part == '0) begin
      pick.chosen_index = '0;
      pick.pick_status  = PICK_NONE;
    end else if (total == '0) begin
      pick.chosen_index = first_idx;
      pick.pick_status  = PICK_ZERO;
    end else if (hit != '0) begin
      pick.chosen_index = hit_idx;
      pick.pick_status  = PICK_HIT;
    end else begin
      pick.chosen_index = last_idx;
      pick.pick_status  = PICK_LAST;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/weighted_layer_select.sv
// weighted_layer_select: roulette-wheel pick of one of up to six weighted
// entries.
//
// Channels: req carries one roll word (17-bit fixed point, 65536 = one) and
// rsp returns one word per roll with chosen_index and pick_status. Both use
// valid/ready; a word moves on a rising edge where both are high.
// Configuration: write cfg_data to register cfg_index when cfg_en is high
// (0 entry count, 1 enable mask, 2..7 weights). Write only while idle.
//
// Pipeline: a roll accepted on req passes through the roll register, one
// 17x13 multiply plus six compares, then the result register. Throughput
// is one roll per cycle while rsp does not stall.
// When rsp stalls, the result register holds and the roll register fills;
// req.ready drops only once both are full, and rises again in the cycle the
// receiver takes the result.
// Reset (rst, synchronous) clears both valid flags and all configuration
// registers, so with nothing enabled every roll returns index 0, status 2.

`default_nettype none

module weighted_layer_select import wls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wls_req_if.sink               req,
  wls_rsp_if.source             rsp
);

  wls_cfg_t          cfg;
  logic              s1_valid;
  logic [ROLL_W-1:0] s1_roll;
  logic [ROLL_W-1:0] roll_sat;
  logic              s1_go;
  logic              req_take;
  pick_t             pick_next;
  pick_t             pick;
  logic              out_valid;

  // Configuration registers; indexes past the last weight are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ENTRY_COUNT: cfg.entry_count <= cfg_data[COUNT_W-1:0];
        REG_ENABLE_MASK: cfg.enable_mask <= cfg_data[MAX_ENTRIES-1:0];
        default: begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cfg_index == REG_WEIGHT_BASE + CFG_IDX_W'(i)) begin
              cfg.weight[i] <= cfg_data[WEIGHT_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Advance the roll stage whenever the result register is free or drains.
  assign s1_go     = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_go;
  assign req_take  = req.valid && req.ready;

  // Clamp rolls above one as they enter.
  assign roll_sat = (req.roll > ROLL_ONE) ? ROLL_ONE : req.roll;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_roll <= roll_sat;
    end
  end

  wls_pick u_pick (
    .cfg  (cfg),
    .roll (s1_roll),
    .pick (pick_next)
  );

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      pick <= pick_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.chosen_index = pick.chosen_index;
  assign rsp.pick_status  = pick.pick_status;

endmodule

`default_nettype wire
